/* design/loopback_frame_ring_with_claim_unit_defines.svh */
// Assertion macros shared by the ring design.
`ifndef LOOPBACK_FRAME_RING_WITH_CLAIM_UNIT_DEFINES_SVH
`define LOOPBACK_FRAME_RING_WITH_CLAIM_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LFRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lfrc_pkg.sv */
package lfrc_pkg;

  localparam int REGIONS_DEF      = 8;
  localparam int REGION_SHIFT_DEF = 11;
  localparam int HEADER_OCTETS    = 14;
  localparam int PAYLOAD_MAX      = 1500;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [7:0]  IPV4_LOOP_NET   = 8'd127;
  localparam logic [63:0] IPV6_LOOP_UPPER = 64'h0;
  localparam logic [63:0] IPV6_LOOP_LOWER = 64'h1;

  typedef enum logic [2:0] {
    OP_WRITE_BYTE = 3'd0,
    OP_OUTPUT     = 3'd1,
    OP_CLAIM      = 3'd2,
    OP_RELEASE    = 3'd3,
    OP_READ_BYTE  = 3'd4,
    OP_OWNS4      = 3'd5,
    OP_OWNS6      = 3'd6
  } lfrc_op_t;

  typedef enum logic [1:0] {
    RC_OK   = 2'd0,
    RC_ERR  = 2'd1,
    RC_BUSY = 2'd2
  } lfrc_rc_t;

  typedef enum logic {
    BK_IDLE    = 1'b0,
    BK_DELIVER = 1'b1
  } lfrc_bk_state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [10:0] frame_length;
    logic [10:0] byte_offset;
    logic [7:0]  data_byte;
    logic [31:0] ipv4_address;
    logic [63:0] ipv6_upper;
    logic [63:0] ipv6_lower;
  } lfrc_in_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [2:0]  region_index;
    logic [3:0]  frames_waiting;
    logic [10:0] claimed_length;
    logic        is_loopback;
    logic [7:0]  byte_out;
  } lfrc_out_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [2:0]  opcode;
    logic        len_ok;
    logic        is_loop;
    logic [10:0] frame_length;
    logic [10:0] byte_offset;
    logic [7:0]  data_byte;
  } lfrc_cmd_t;

endpackage

/* design/lfrc_queue.sv */
module lfrc_queue #(
  parameter type item_t = logic,
  parameter int  DEPTH  = lfrc_pkg::QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  item_t din,
  input  logic  pop,
  output logic  empty,
  output item_t dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  item_t         slot_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push_ok, pop_ok;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = slot_r[rd_r];
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push_ok) begin
      wr_nxt = (wr_r == LAST) ? '0 : wr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_nxt = (rd_r == LAST) ? '0 : rd_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_r] <= din;
    end
  end

endmodule

/* design/lfrc_front.sv */
module lfrc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [10:0]          cfg_data,
  input  logic                 in_push,
  output logic                 in_full,
  input  lfrc_pkg::lfrc_in_t   in_item,
  input  logic                 cmd_full,
  output logic                 cmd_push,
  output lfrc_pkg::lfrc_cmd_t  cmd
);

  logic [10:0] limit_r;
  logic [10:0] limit_clamped;
  logic [11:0] len_max;
  logic        loop4, loop6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

  assign limit_clamped = (limit_r > 11'(lfrc_pkg::PAYLOAD_MAX)) ?
                         11'(lfrc_pkg::PAYLOAD_MAX) : limit_r;
  assign len_max = {1'b0, limit_clamped} + 12'(lfrc_pkg::HEADER_OCTETS);

  assign loop4 = (in_item.ipv4_address[31:24] == lfrc_pkg::IPV4_LOOP_NET);
  assign loop6 = (in_item.ipv6_upper == lfrc_pkg::IPV6_LOOP_UPPER) &&
                 (in_item.ipv6_lower == lfrc_pkg::IPV6_LOOP_LOWER);

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full;

  always_comb begin
    cmd.opcode       = in_item.opcode;
    cmd.frame_length = in_item.frame_length;
    cmd.byte_offset  = in_item.byte_offset;
    cmd.data_byte    = in_item.data_byte;
    cmd.len_ok       = (in_item.frame_length != '0) &&
                       ({1'b0, in_item.frame_length} <= len_max);
    // Only the address tests carry an answer.
    if (in_item.opcode == lfrc_pkg::OP_OWNS4) begin
      cmd.is_loop = loop4;
    end else if (in_item.opcode == lfrc_pkg::OP_OWNS6) begin
      cmd.is_loop = loop6;
    end else begin
      cmd.is_loop = 1'b0;
    end
  end

endmodule

/* design/lfrc_back.sv */
`include "loopback_frame_ring_with_claim_unit_defines.svh"

module lfrc_back #(
  parameter int REGIONS      = lfrc_pkg::REGIONS_DEF,
  parameter int REGION_SHIFT = lfrc_pkg::REGION_SHIFT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  input  lfrc_pkg::lfrc_cmd_t  cmd,
  input  logic                 res_full,
  output logic                 res_push,
  output lfrc_pkg::lfrc_out_t  res
);

  localparam int PTR_W       = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int OCC_W       = $clog2(REGIONS + 1);
  localparam int STORE_DEPTH = REGIONS << REGION_SHIFT;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(REGIONS - 1);

  lfrc_pkg::lfrc_bk_state_t state_r, state_nxt;

  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic                claim_r, claim_nxt;
  lfrc_pkg::lfrc_out_t res_r, res_nxt;
  logic                sel_byte_r, sel_byte_nxt;
  logic                sel_len_r, sel_len_nxt;
  logic                ring_full;

  logic [7:0]          store_mem [STORE_DEPTH];
  logic [STORE_AW-1:0] store_addr;
  logic                store_we;
  logic [7:0]          store_q_r;

  logic [10:0]         len_mem [REGIONS];
  logic                len_we;
  logic [10:0]         len_q_r;

  assign ring_full = (occ_r == OCC_W'(REGIONS));

  always_comb begin
    unique case (state_r)
      lfrc_pkg::BK_IDLE: begin
        state_nxt = (!cmd_empty && !res_full) ? lfrc_pkg::BK_DELIVER : lfrc_pkg::BK_IDLE;
      end
      lfrc_pkg::BK_DELIVER: begin
        state_nxt = lfrc_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = lfrc_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop  = (state_r == lfrc_pkg::BK_IDLE) && !cmd_empty && !res_full;
    res_push = (state_r == lfrc_pkg::BK_DELIVER);
    res      = res_r;
    res.byte_out       = sel_byte_r ? store_q_r : '0;
    res.claimed_length = sel_len_r ? len_q_r : '0;
  end

  // Execute one item against the ring state.
  always_comb begin
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    occ_nxt      = occ_r;
    claim_nxt    = claim_r;
    sel_byte_nxt = 1'b0;
    sel_len_nxt  = 1'b0;
    store_we     = 1'b0;
    len_we       = 1'b0;
    res_nxt      = '0;
    res_nxt.result_code    = lfrc_pkg::RC_ERR;
    res_nxt.frames_waiting = 4'(occ_r);
    if (cmd.opcode == lfrc_pkg::OP_READ_BYTE) begin
      store_addr = STORE_AW'({rd_ptr_r, REGION_SHIFT'(cmd.byte_offset)});
    end else begin
      store_addr = STORE_AW'({wr_ptr_r, REGION_SHIFT'(cmd.byte_offset)});
    end
    if (cmd_pop) begin
      unique case (cmd.opcode)
        lfrc_pkg::OP_WRITE_BYTE: begin
          // Drop the byte on a full ring so the head frame survives.
          if (ring_full) begin
            res_nxt.result_code = lfrc_pkg::RC_BUSY;
          end else begin
            store_we = 1'b1;
            res_nxt.result_code  = lfrc_pkg::RC_OK;
            res_nxt.region_index = 3'(wr_ptr_r);
          end
        end
        lfrc_pkg::OP_OUTPUT: begin
          if (!cmd.len_ok) begin
            res_nxt.frames_waiting = '0;
          end else if (ring_full) begin
            res_nxt.result_code = lfrc_pkg::RC_BUSY;
          end else begin
            len_we     = 1'b1;
            wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
            occ_nxt    = occ_r + 1'b1;
            res_nxt.result_code    = lfrc_pkg::RC_OK;
            res_nxt.region_index   = 3'(wr_ptr_r);
            res_nxt.frames_waiting = 4'(occ_nxt);
          end
        end
        lfrc_pkg::OP_CLAIM: begin
          if (claim_r) begin
            res_nxt.result_code = lfrc_pkg::RC_ERR;
          end else if (occ_r == '0) begin
            res_nxt.result_code = lfrc_pkg::RC_BUSY;
          end else begin
            claim_nxt   = 1'b1;
            sel_len_nxt = 1'b1;
            res_nxt.result_code  = lfrc_pkg::RC_OK;
            res_nxt.region_index = 3'(rd_ptr_r);
          end
        end
        lfrc_pkg::OP_RELEASE: begin
          if (claim_r) begin
            rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
            occ_nxt    = (occ_r != '0) ? occ_r - 1'b1 : occ_r;
            claim_nxt  = 1'b0;
            res_nxt.result_code    = lfrc_pkg::RC_OK;
            res_nxt.region_index   = 3'(rd_ptr_r);
            res_nxt.frames_waiting = 4'(occ_nxt);
          end
        end
        lfrc_pkg::OP_READ_BYTE: begin
          if (claim_r) begin
            sel_byte_nxt = 1'b1;
            res_nxt.result_code  = lfrc_pkg::RC_OK;
            res_nxt.region_index = 3'(rd_ptr_r);
          end
        end
        lfrc_pkg::OP_OWNS4, lfrc_pkg::OP_OWNS6: begin
          res_nxt.result_code = lfrc_pkg::RC_OK;
          res_nxt.is_loopback = cmd.is_loop;
        end
        default: begin
          res_nxt.result_code = lfrc_pkg::RC_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lfrc_pkg::BK_IDLE;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      occ_r    <= '0;
      claim_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      occ_r    <= occ_nxt;
      claim_r  <= claim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res_r      <= res_nxt;
      sel_byte_r <= sel_byte_nxt;
      sel_len_r  <= sel_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_addr] <= cmd.data_byte;
    end
    store_q_r <= store_mem[store_addr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[wr_ptr_r] <= cmd.frame_length;
    end
    len_q_r <= len_mem[rd_ptr_r];
  end

  `LFRC_ASSERT_IMPL(a_occ_bound, clk, rst_n, 1'b1, occ_r <= OCC_W'(REGIONS), "occupancy overrun")
  `LFRC_ASSERT_IMPL(a_claim_nonempty, clk, rst_n, claim_r, occ_r != '0, "claim on empty ring")
  `LFRC_ASSERT_IMPL(a_deliver_room, clk, rst_n, res_push, !res_full, "result queue full")
  `LFRC_ASSERT_NEXT(a_exec_deliver, clk, rst_n, cmd_pop, res_push, "item not delivered")

endmodule

/* design/loopback_frame_ring_with_claim_unit.sv */
// Ring of frame regions for a loopback interface. Items enter through a queue-like
// port (push/full) and each one gives exactly one result on the output queue
// (empty/pop), in order. The front stage classifies an item in the cycle it is
// pushed and places it in a two-entry command queue; the back stage updates the
// ring state and addresses the frame store or the length table in its idle
// state, then delivers the registered read data into the two-entry result
// queue in its deliver state. It takes no new item before it has delivered the
// last one, and waits while the result queue is full. The user must write the
// payload limit through cfg_we/cfg_data only while the block is idle; the block
// does not enforce this. Store bytes must be written before they are read back.
module loopback_frame_ring_with_claim_unit #(
  parameter int REGIONS      = lfrc_pkg::REGIONS_DEF,
  parameter int REGION_SHIFT = lfrc_pkg::REGION_SHIFT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_data,
  input  logic                in_push,
  output logic                in_full,
  input  lfrc_pkg::lfrc_in_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output lfrc_pkg::lfrc_out_t out_item
);

  lfrc_pkg::lfrc_cmd_t cmd_in, cmd_out;
  logic                cmd_push, cmd_full, cmd_pop, cmd_empty;
  lfrc_pkg::lfrc_out_t res;
  logic                res_push, res_full;

  lfrc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  lfrc_queue #(
    .item_t (lfrc_pkg::lfrc_cmd_t),
    .DEPTH  (lfrc_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .full  (cmd_full),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_out)
  );

  lfrc_back #(
    .REGIONS      (REGIONS),
    .REGION_SHIFT (REGION_SHIFT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd_out),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  lfrc_queue #(
    .item_t (lfrc_pkg::lfrc_out_t),
    .DEPTH  (lfrc_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (out_item)
  );

endmodule
